>>> rtl/nfc_pkg.sv
// Shared types, command codes and register indexes for the NMEA frame capture block.
// No dependencies; every other file but nfc_ram refers to this package by scoped name.
package nfc_pkg;

  // Default sizes of the byte store and the frame table.
  localparam int DEF_BUF_DEPTH   = 256;
  localparam int DEF_FRAME_SLOTS = 16;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Command codes of the input word.
  localparam logic [1:0] CMD_RECEIVE   = 2'd0;
  localparam logic [1:0] CMD_CLEAR     = 2'd1;
  localparam logic [1:0] CMD_READ_BUF  = 2'd2;
  localparam logic [1:0] CMD_READ_SLOT = 2'd3;

  // Receive modes.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RAW  = 2'd1;
  localparam logic [1:0] MODE_NMEA = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_RX_MODE    = 3'd0;
  localparam logic [2:0] REG_START_BYTE = 3'd1;
  localparam logic [2:0] REG_END_BYTE_A = 3'd2;
  localparam logic [2:0] REG_END_BYTE_B = 3'd3;
  localparam logic [2:0] REG_RAW_HEADER = 3'd4;

  // Operation classes decided by the front.
  typedef enum logic [2:0] {
    OP_IDLE_BYTE,
    OP_RAW_BYTE,
    OP_NMEA_BYTE,
    OP_BAD_MODE,
    OP_CLEAR,
    OP_READ_BUF,
    OP_READ_SLOT
  } op_t;

  // Byte classification against the configured marker values.
  typedef struct packed {
    logic is_start;
    logic is_end;
    logic is_header;
  } byte_class_t;

  // One queued word.
  typedef struct packed {
    op_t         op;
    byte_class_t cls;
    logic [7:0]  data_byte;
    logic [7:0]  read_index;
  } q_entry_t;

endpackage

>>> rtl/nmea_frame_capture.sv
// An accepted word passes through the queue, then the back stage into the result register.
// Throughput: one word per cycle while the output is not stalled, set by the single pass
// through the back stage and its write or read of the byte store and the frame tables.
// Reset (rst, synchronous): clears the queue, the capture indexes and flags and the
// configuration registers to their defaults; the byte store and tables are not cleared.
//
// Top level of the NMEA frame capture block. It depends on nfc_pkg and instantiates
// nfc_front, nfc_queue and nfc_back (which holds the nfc_ram memories).
module nmea_frame_capture #(
  parameter int BUF_DEPTH   = nfc_pkg::DEF_BUF_DEPTH,
  parameter int FRAME_SLOTS = nfc_pkg::DEF_FRAME_SLOTS,
  localparam int WW = $clog2(BUF_DEPTH + 1),
  localparam int FW = $clog2(FRAME_SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  // Configuration write channel.
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  // Input word channel.
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    cmd,
  input  logic [7:0]    data_byte,
  input  logic [7:0]    read_index,
  // Result word channel.
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    read_byte,
  output logic [7:0]    header_pos,
  output logic [7:0]    end_pos,
  output logic [FW-1:0] frame_count,
  output logic [WW-1:0] write_count,
  output logic          frame_done,
  output logic          receiving,
  output logic          buffer_full,
  output logic          extra_header,
  output logic          overflow_reset
);

  // The front turns each incoming word into an operation class, with the byte already compared
  // against the start, end and raw header values. The user must write configuration only while
  // the block is idle (it does not enforce this), so classifying ahead of the back is safe.
  nfc_pkg::q_entry_t front_entry;
  nfc_pkg::q_entry_t head_entry;
  logic              q_full;
  logic              q_head_valid;
  logic              q_pop;
  logic              push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  nfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .read_index (read_index),
    .entry      (front_entry)
  );

  // The queue lets the input side keep taking words while a result waits downstream.
  nfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (head_entry)
  );

  // The back executes one word per cycle when not stalled: it updates the write and frame
  // indexes and the sticky flags, writes or reads the memories, and registers the result word.
  nfc_back #(
    .BUF_DEPTH   (BUF_DEPTH),
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_head_valid),
    .q_entry        (head_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_byte      (read_byte),
    .header_pos     (header_pos),
    .end_pos        (end_pos),
    .frame_count    (frame_count),
    .write_count    (write_count),
    .frame_done     (frame_done),
    .receiving      (receiving),
    .buffer_full    (buffer_full),
    .extra_header   (extra_header),
    .overflow_reset (overflow_reset)
  );

endmodule

>>> rtl/nfc_ram.sv
// Generic simple dual-port RAM with a registered read port that holds its data between reads.
// Used for the byte store and both frame position tables; no package dependency.
module nfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/nfc_front.sv
// Front of the frame capture block: configuration registers and word classification.
// Depends on nfc_pkg for command, mode and register codes and for the queue word type.
module nfc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic [1:0]         cmd,
  input  logic [7:0]         data_byte,
  input  logic [7:0]         read_index,
  output nfc_pkg::q_entry_t  entry
);

  logic [1:0] rx_mode;
  logic [7:0] start_byte;
  logic [7:0] end_byte_a;
  logic [7:0] end_byte_b;
  logic [7:0] raw_header;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode    <= nfc_pkg::MODE_IDLE;
      start_byte <= 8'd36;
      end_byte_a <= 8'd13;
      end_byte_b <= 8'd10;
      raw_header <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        nfc_pkg::REG_RX_MODE:    rx_mode    <= cfg_data[1:0];
        nfc_pkg::REG_START_BYTE: start_byte <= cfg_data;
        nfc_pkg::REG_END_BYTE_A: end_byte_a <= cfg_data;
        nfc_pkg::REG_END_BYTE_B: end_byte_b <= cfg_data;
        nfc_pkg::REG_RAW_HEADER: raw_header <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    entry.data_byte     = data_byte;
    entry.read_index    = read_index;
    // A zero byte never opens a sentence, whatever the start byte holds.
    entry.cls.is_start  = (data_byte != 8'd0) && (data_byte == start_byte);
    entry.cls.is_end    = (data_byte == end_byte_a) || (data_byte == end_byte_b);
    entry.cls.is_header = (raw_header != 8'd0) && (data_byte == raw_header);
    case (cmd)
      nfc_pkg::CMD_RECEIVE: begin
        case (rx_mode)
          nfc_pkg::MODE_IDLE: entry.op = nfc_pkg::OP_IDLE_BYTE;
          nfc_pkg::MODE_RAW:  entry.op = nfc_pkg::OP_RAW_BYTE;
          nfc_pkg::MODE_NMEA: entry.op = nfc_pkg::OP_NMEA_BYTE;
          default:            entry.op = nfc_pkg::OP_BAD_MODE;
        endcase
      end
      nfc_pkg::CMD_CLEAR:    entry.op = nfc_pkg::OP_CLEAR;
      nfc_pkg::CMD_READ_BUF: entry.op = nfc_pkg::OP_READ_BUF;
      default:               entry.op = nfc_pkg::OP_READ_SLOT;
    endcase
  end

endmodule

>>> rtl/nfc_queue.sv
// Short flop-based queue that decouples the front from the back.
// Depends on nfc_pkg for the queue word type and depth.
module nfc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  nfc_pkg::q_entry_t  push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output nfc_pkg::q_entry_t  head_entry
);

  nfc_pkg::q_entry_t               entries [nfc_pkg::Q_DEPTH];
  logic [nfc_pkg::Q_PW-1:0]        wr_ptr;
  logic [nfc_pkg::Q_PW-1:0]        rd_ptr;
  logic [nfc_pkg::Q_CW-1:0]        count;

  assign full       = (count == nfc_pkg::Q_CW'(nfc_pkg::Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == nfc_pkg::Q_PW'(nfc_pkg::Q_DEPTH - 1)) ? '0
                                                                  : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == nfc_pkg::Q_PW'(nfc_pkg::Q_DEPTH - 1)) ? '0
                                                                  : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/nfc_back.sv
// Back of the frame capture block: capture state, byte store, frame tables and result register.
// Depends on nfc_pkg for the queue word type and on nfc_ram for the three memories.
module nfc_back #(
  parameter int BUF_DEPTH   = nfc_pkg::DEF_BUF_DEPTH,
  parameter int FRAME_SLOTS = nfc_pkg::DEF_FRAME_SLOTS,
  localparam int WW = $clog2(BUF_DEPTH + 1),
  localparam int FW = $clog2(FRAME_SLOTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  nfc_pkg::q_entry_t  q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         read_byte,
  output logic [7:0]         header_pos,
  output logic [7:0]         end_pos,
  output logic [FW-1:0]      frame_count,
  output logic [WW-1:0]      write_count,
  output logic               frame_done,
  output logic               receiving,
  output logic               buffer_full,
  output logic               extra_header,
  output logic               overflow_reset
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int SW = $clog2(FRAME_SLOTS);

  // Capture state.
  logic [WW-1:0] wi, wi_next;
  logic [FW-1:0] fi, fi_next;
  logic          in_sentence, in_sentence_next;
  logic          recv, recv_next;
  logic          full, full_next;
  logic          extra, extra_next;

  // Memory controls.
  logic          st_we, st_re;
  logic          start_we, end_we, slot_re;
  logic [7:0]    end_wdata;
  logic [7:0]    st_rdata, start_rdata, end_rdata;

  // Step results.
  logic          done, forced, rb_sel, slot_sel;
  logic          wi_full, buf_room, slot_room, raw_slot_room, idx_buf_ok, idx_slot_ok;

  // Result register.
  logic          p1_valid;
  logic          p1_done, p1_forced, p1_rb_sel, p1_slot_sel;
  logic [FW-1:0] p1_fi;
  logic [WW-1:0] p1_wi;
  logic          p1_recv, p1_full, p1_extra;

  assign q_pop = q_valid && (!p1_valid || !out_stall);

  assign wi_full       = (wi >= WW'(BUF_DEPTH));
  assign buf_room      = (wi < WW'(BUF_DEPTH - 1));
  assign slot_room     = (fi < FW'(FRAME_SLOTS));
  assign raw_slot_room = (fi < FW'(FRAME_SLOTS - 1));
  assign idx_buf_ok    = (32'(q_entry.read_index) < 32'(BUF_DEPTH));
  assign idx_slot_ok   = (32'(q_entry.read_index) < 32'(FRAME_SLOTS));

  always_comb begin
    wi_next          = wi;
    fi_next          = fi;
    in_sentence_next = in_sentence;
    recv_next        = recv;
    full_next        = full;
    extra_next       = extra;
    st_we            = 1'b0;
    start_we         = 1'b0;
    end_we           = 1'b0;
    end_wdata        = 8'd0;
    done             = 1'b0;
    forced           = 1'b0;
    rb_sel           = 1'b0;
    slot_sel         = 1'b0;
    case (q_entry.op)
      nfc_pkg::OP_IDLE_BYTE: begin
        forced = wi_full;
      end
      nfc_pkg::OP_BAD_MODE: begin
        forced = 1'b1;
      end
      nfc_pkg::OP_RAW_BYTE: begin
        if (wi_full) begin
          forced = 1'b1;
        end else if (buf_room) begin
          st_we = 1'b1;
          if (q_entry.cls.is_header) begin
            if (raw_slot_room) begin
              start_we = 1'b1;
              end_we   = 1'b1;
              fi_next  = fi + 1'b1;
            end else begin
              extra_next = 1'b1;
            end
          end
          wi_next = wi + 1'b1;
        end else begin
          full_next = 1'b1;
        end
      end
      nfc_pkg::OP_NMEA_BYTE: begin
        if (wi_full) begin
          forced = 1'b1;
        end else if (!in_sentence) begin
          if (q_entry.cls.is_start) begin
            if (slot_room) begin
              st_we            = 1'b1;
              start_we         = 1'b1;
              end_we           = 1'b1;
              wi_next          = wi + 1'b1;
              in_sentence_next = 1'b1;
              recv_next        = 1'b1;
            end else begin
              forced = 1'b1;
            end
          end
        end else begin
          st_we   = 1'b1;
          wi_next = wi + 1'b1;
          if (q_entry.cls.is_end) begin
            // Past the last slot the sentence still counts but leaves no end mark.
            end_we           = slot_room;
            end_wdata        = 8'(wi);
            in_sentence_next = 1'b0;
            recv_next        = 1'b0;
            fi_next          = fi + 1'b1;
            done             = 1'b1;
          end
        end
      end
      nfc_pkg::OP_CLEAR: begin
        forced = 1'b0;
      end
      nfc_pkg::OP_READ_BUF: begin
        rb_sel = idx_buf_ok;
      end
      default: begin
        slot_sel = idx_slot_ok;
      end
    endcase
    if (forced || q_entry.op == nfc_pkg::OP_CLEAR) begin
      wi_next          = '0;
      fi_next          = '0;
      in_sentence_next = 1'b0;
      recv_next        = 1'b0;
      full_next        = 1'b0;
      extra_next       = 1'b0;
    end
  end

  assign st_re   = q_pop && rb_sel;
  assign slot_re = q_pop && slot_sel;

  nfc_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_store (
    .clk   (clk),
    .we    (q_pop && st_we),
    .waddr (wi[AW-1:0]),
    .wdata (q_entry.data_byte),
    .re    (st_re),
    .raddr (AW'(q_entry.read_index)),
    .rdata (st_rdata)
  );

  nfc_ram #(.WIDTH(8), .DEPTH(FRAME_SLOTS)) u_start_tab (
    .clk   (clk),
    .we    (q_pop && start_we),
    .waddr (fi[SW-1:0]),
    .wdata (8'(wi)),
    .re    (slot_re),
    .raddr (SW'(q_entry.read_index)),
    .rdata (start_rdata)
  );

  nfc_ram #(.WIDTH(8), .DEPTH(FRAME_SLOTS)) u_end_tab (
    .clk   (clk),
    .we    (q_pop && end_we),
    .waddr (fi[SW-1:0]),
    .wdata (end_wdata),
    .re    (slot_re),
    .raddr (SW'(q_entry.read_index)),
    .rdata (end_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wi          <= '0;
      fi          <= '0;
      in_sentence <= 1'b0;
      recv        <= 1'b0;
      full        <= 1'b0;
      extra       <= 1'b0;
      p1_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        wi          <= wi_next;
        fi          <= fi_next;
        in_sentence <= in_sentence_next;
        recv        <= recv_next;
        full        <= full_next;
        extra       <= extra_next;
        p1_valid    <= 1'b1;
      end else if (!out_stall) begin
        p1_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p1_done     <= done;
      p1_forced   <= forced;
      p1_rb_sel   <= rb_sel;
      p1_slot_sel <= slot_sel;
      p1_fi       <= fi_next;
      p1_wi       <= wi_next;
      p1_recv     <= recv_next;
      p1_full     <= full_next;
      p1_extra    <= extra_next;
    end
  end

  // Memory read data holds until the next read, so a stalled result stays put.
  assign out_valid      = p1_valid;
  assign read_byte      = p1_rb_sel ? st_rdata : 8'd0;
  assign header_pos     = p1_slot_sel ? start_rdata : 8'd0;
  assign end_pos        = p1_slot_sel ? end_rdata : 8'd0;
  assign frame_count    = p1_fi;
  assign write_count    = p1_wi;
  assign frame_done     = p1_done;
  assign receiving      = p1_recv;
  assign buffer_full    = p1_full;
  assign extra_header   = p1_extra;
  assign overflow_reset = p1_forced;

endmodule
